// File: design/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types, codes and header decode helpers for the token stream block.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int DEF_MAX_DEPTH = 16;
	localparam logic [7:0] KLIMIT_RESET = 8'd64;
	localparam logic [4:0] FIXLEN_MASK = 5'h1f;

	localparam logic [7:0] HDR_FIXMAP   = 8'h80;
	localparam logic [7:0] HDR_FIXARR   = 8'h90;
	localparam logic [7:0] HDR_FIXSTR   = 8'ha0;
	localparam logic [7:0] HDR_NIL      = 8'hc0;
	localparam logic [7:0] HDR_NEVER    = 8'hc1;
	localparam logic [7:0] HDR_FALSE    = 8'hc2;
	localparam logic [7:0] HDR_TRUE     = 8'hc3;
	localparam logic [7:0] HDR_BIN8     = 8'hc4;
	localparam logic [7:0] HDR_EXT32    = 8'hc9;
	localparam logic [7:0] HDR_F32      = 8'hca;
	localparam logic [7:0] HDR_F64      = 8'hcb;
	localparam logic [7:0] HDR_U8       = 8'hcc;
	localparam logic [7:0] HDR_U16      = 8'hcd;
	localparam logic [7:0] HDR_U32      = 8'hce;
	localparam logic [7:0] HDR_U64      = 8'hcf;
	localparam logic [7:0] HDR_I8       = 8'hd0;
	localparam logic [7:0] HDR_I16      = 8'hd1;
	localparam logic [7:0] HDR_I32      = 8'hd2;
	localparam logic [7:0] HDR_I64      = 8'hd3;
	localparam logic [7:0] HDR_FIXEXT1  = 8'hd4;
	localparam logic [7:0] HDR_FIXEXT16 = 8'hd8;
	localparam logic [7:0] HDR_STR8     = 8'hd9;
	localparam logic [7:0] HDR_STR16    = 8'hda;
	localparam logic [7:0] HDR_STR32    = 8'hdb;
	localparam logic [7:0] HDR_ARR16    = 8'hdc;
	localparam logic [7:0] HDR_ARR32    = 8'hdd;
	localparam logic [7:0] HDR_MAP16    = 8'hde;
	localparam logic [7:0] HDR_MAP32    = 8'hdf;
	localparam logic [7:0] HDR_NEGFIX   = 8'he0;

	typedef enum logic [3:0] {
		K_NULL    = 4'd0,
		K_FALSE   = 4'd1,
		K_TRUE    = 4'd2,
		K_INT     = 4'd3,
		K_F32     = 4'd4,
		K_F64     = 4'd5,
		K_STR     = 4'd6,
		K_STRBYTE = 4'd7,
		K_KEY     = 4'd8,
		K_KEYBYTE = 4'd9,
		K_MAP     = 4'd10,
		K_ARRAY   = 4'd11,
		K_CLOSE   = 4'd12,
		K_ERROR   = 4'd13,
		K_DONE    = 4'd14
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE      = 3'd0,
		E_TRUNC     = 3'd1,
		E_UNSUP     = 3'd2,
		E_KEYTYPE   = 3'd3,
		E_ROOT      = 3'd4,
		E_DEPTH     = 3'd5,
		E_KEYLEN    = 3'd6
	} err_t;

	typedef enum logic [3:0] {
		C_POSFIX,
		C_NEGFIX,
		C_FIXMAP,
		C_FIXARR,
		C_FIXSTR,
		C_NIL,
		C_FALSE,
		C_TRUE,
		C_COLLECT,
		C_STRHDR,
		C_UNSUP
	} hdr_class_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eob;
		logic       som;
		hdr_class_t cls;
		logic       cont;
	} mst_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic [31:0] length;
		logic [4:0]  depth;
		err_t        err;
		logic        last;
	} tok_t;

	function automatic hdr_class_t classify(input logic [7:0] h);
		hdr_class_t c;
		if (h < HDR_FIXMAP) begin
			c = C_POSFIX;
		end else if (h >= HDR_NEGFIX) begin
			c = C_NEGFIX;
		end else if (h[7:4] == HDR_FIXMAP[7:4]) begin
			c = C_FIXMAP;
		end else if (h[7:4] == HDR_FIXARR[7:4]) begin
			c = C_FIXARR;
		end else if (h[7:5] == HDR_FIXSTR[7:5]) begin
			c = C_FIXSTR;
		end else if (h == HDR_NIL) begin
			c = C_NIL;
		end else if (h == HDR_FALSE) begin
			c = C_FALSE;
		end else if (h == HDR_TRUE) begin
			c = C_TRUE;
		end else if (h == HDR_NEVER || (h >= HDR_BIN8 && h <= HDR_EXT32) || h == HDR_U64
				|| (h >= HDR_FIXEXT1 && h <= HDR_FIXEXT16)) begin
			c = C_UNSUP;
		end else if (h >= HDR_STR8 && h <= HDR_STR32) begin
			c = C_STRHDR;
		end else begin
			c = C_COLLECT;
		end
		return c;
	endfunction

	function automatic logic [3:0] operand_bytes(input logic [7:0] h);
		logic [3:0] n;
		case (h) inside
			HDR_U8, HDR_I8, HDR_STR8: n = 4'd1;
			HDR_U16, HDR_I16, HDR_STR16, HDR_ARR16, HDR_MAP16: n = 4'd2;
			HDR_F32, HDR_U32, HDR_I32, HDR_STR32, HDR_ARR32, HDR_MAP32: n = 4'd4;
			HDR_F64, HDR_I64: n = 4'd8;
			default: n = 4'd1;
		endcase
		return n;
	endfunction

endpackage

// File: design/mst_if.sv
// ----------------------------------------------------------------------------
// mst_if
// Channel interfaces: encoded byte input, token output, key limit write.
// ----------------------------------------------------------------------------
interface mst_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;
	logic       start_of_message;

	modport source (output valid, data_byte, end_of_buffer, start_of_message, input ready);
	modport sink (input valid, data_byte, end_of_buffer, start_of_message, output ready);
endinterface

interface mst_token_if;
	logic               valid;
	logic               ready;
	logic [3:0]         token_kind;
	logic signed [63:0] token_value;
	logic [31:0]        token_length;
	logic [4:0]         nest_depth;
	logic [2:0]         error_code;
	logic               last_event;

	modport source (output valid, token_kind, token_value, token_length, nest_depth,
		error_code, last_event, input ready);
	modport sink (input valid, token_kind, token_value, token_length, nest_depth,
		error_code, last_event, output ready);
endinterface

interface mst_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_length_limit;

	modport source (output valid, key_length_limit, input ready);
	modport sink (input valid, key_length_limit, output ready);
endinterface

// File: design/mst_ram.sv
// ----------------------------------------------------------------------------
// mst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mst_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/mst_front.sv
// ----------------------------------------------------------------------------
// mst_front
// Accepts byte beats, classifies them as headers and queues them for the back.
// ----------------------------------------------------------------------------
module mst_front (
	input  logic              clk,
	input  logic              arst_n,
	mst_byte_if.sink          bytes,
	output mst_pkg::mst_item_t item,
	output logic              item_valid,
	input  logic              item_ready
);
	import mst_pkg::*;

	mst_item_t  fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	mst_item_t  in_item;

	assign bytes.ready = (cnt_q != 2'd2);
	assign push = bytes.valid && bytes.ready;
	assign pop = item_valid && item_ready;
	assign item_valid = (cnt_q != 2'd0);
	assign item = fifo_q[rd_q];

	always_comb begin
		in_item.data = bytes.data_byte;
		in_item.eob = bytes.end_of_buffer;
		in_item.som = bytes.start_of_message;
		in_item.cls = classify(bytes.data_byte);
		in_item.cont = (in_item.cls == C_FIXMAP) || (in_item.cls == C_FIXARR)
			|| (bytes.data_byte >= HDR_ARR16 && bytes.data_byte <= HDR_MAP32);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: design/mst_back.sv
// ----------------------------------------------------------------------------
// mst_back
// Parser sequencer: carries out queued bytes, keeps the nesting stack and
// emits token beats through a hold stage and an output register.
// ----------------------------------------------------------------------------
module mst_back #(
	parameter int MAX_DEPTH = mst_pkg::DEF_MAX_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mst_pkg::mst_item_t item,
	input  logic              item_valid,
	output logic              item_ready,
	mst_cfg_if.sink           cfg,
	mst_token_if.source       tokens
);
	import mst_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int EW = 34;

	typedef enum logic [6:0] {
		P_ROOT    = 7'b0000001,
		P_HEADER  = 7'b0000010,
		P_COLLECT = 7'b0000100,
		P_STRB    = 7'b0001000,
		P_KEYB    = 7'b0010000,
		P_DONE    = 7'b0100000,
		P_ERROR   = 7'b1000000
	} phase_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ECLOSE = 6'b000010,
		S_FIN    = 6'b000100,
		S_POPRD  = 6'b001000,
		S_EOB    = 6'b010000,
		S_FLUSH  = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	phase_t        phase_q, phase_d, eff_phase;
	logic [7:0]    hdr_q, hdr_d;
	logic [3:0]    cbytes_q, cbytes_d;
	logic [63:0]   vshift_q, vshift_d, nv;
	logic [31:0]   srem_q, srem_d;
	logic [DW-1:0] dp_q, dp_d, eff_dp;
	logic [31:0]   top_cnt_q, top_cnt_d, cm1;
	logic          top_map_q, top_map_d;
	logic          top_await_q, top_await_d;
	logic          eob_q, eob_d;
	logic [7:0]    klimit_q;
	tok_t          hold_q, out_q, ev;
	logic          hold_v_q, out_v_q;
	logic          ev_gen, take, go, out_free, key_exp;
	logic          do_fail, do_scalar, do_str, do_collect, do_cont;
	err_t          fail_code;
	kind_t         sc_kind;
	logic [63:0]   sc_val;
	logic          s_key, c_map;
	logic [31:0]   s_len, c_cnt;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;
	logic [DW+4:0] dpx;
	logic [DW-1:0] dp_m1, dp_m2, dp_p1;

	function automatic logic [4:0] d5(input logic [DW-1:0] d);
		logic [DW+4:0] t;
		t = {5'd0, d};
		return t[4:0];
	endfunction

	mst_ram #(.WIDTH(EW), .DEPTH(MAX_DEPTH)) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_free = !out_v_q || tokens.ready;
	assign go = (state_q == S_FLUSH) ? (!hold_v_q || out_free)
		: (!ev_gen || !hold_v_q || out_free);
	assign item_ready = take && go;

	assign cfg.ready = 1'b1;
	assign tokens.valid = out_v_q;
	assign tokens.token_kind = out_q.kind;
	assign tokens.token_value = $signed(out_q.value);
	assign tokens.token_length = out_q.length;
	assign tokens.nest_depth = out_q.depth;
	assign tokens.error_code = out_q.err;
	assign tokens.last_event = out_q.last;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		hdr_d = hdr_q;
		cbytes_d = cbytes_q;
		vshift_d = vshift_q;
		srem_d = srem_q;
		dp_d = dp_q;
		top_cnt_d = top_cnt_q;
		top_map_d = top_map_q;
		top_await_d = top_await_q;
		eob_d = eob_q;
		eff_phase = phase_q;
		eff_dp = dp_q;
		key_exp = (dp_q != '0) && top_map_q && top_await_q;
		ev_gen = 1'b0;
		ev = '0;
		take = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = '0;
		mem_raddr = '0;
		mem_wdata = {top_cnt_q, top_map_q, top_await_q};
		do_fail = 1'b0;
		do_scalar = 1'b0;
		do_str = 1'b0;
		do_collect = 1'b0;
		do_cont = 1'b0;
		fail_code = E_NONE;
		sc_kind = K_NULL;
		sc_val = '0;
		s_key = 1'b0;
		s_len = '0;
		c_map = 1'b0;
		c_cnt = '0;
		nv = {vshift_q[55:0], item.data};
		cm1 = top_cnt_q - 32'd1;
		dpx = '0;
		dp_m1 = dp_q - DW'(1);
		dp_m2 = dp_q - DW'(2);
		dp_p1 = '0;

		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					take = 1'b1;
					eob_d = item.eob;
					state_d = S_EOB;
					if (item.som) begin
						eff_phase = P_ROOT;
						eff_dp = '0;
						key_exp = 1'b0;
						phase_d = P_ROOT;
						dp_d = '0;
						hdr_d = '0;
						cbytes_d = '0;
						vshift_d = '0;
						srem_d = '0;
					end
					unique case (eff_phase)
						P_ROOT, P_HEADER: begin
							if (key_exp) begin
								if (item.cls == C_FIXSTR) begin
									do_str = 1'b1;
									s_key = 1'b1;
									s_len = {27'd0, item.data[4:0] & FIXLEN_MASK};
								end else if (item.cls == C_STRHDR) begin
									do_collect = 1'b1;
								end else begin
									do_fail = 1'b1;
									fail_code = E_KEYTYPE;
								end
							end else if (item.cls == C_UNSUP) begin
								do_fail = 1'b1;
								fail_code = E_UNSUP;
							end else if (eff_dp == '0 && !item.cont) begin
								do_fail = 1'b1;
								fail_code = E_ROOT;
							end else begin
								unique case (item.cls)
									C_POSFIX: begin
										do_scalar = 1'b1;
										sc_kind = K_INT;
										sc_val = {56'd0, item.data};
									end
									C_NEGFIX: begin
										do_scalar = 1'b1;
										sc_kind = K_INT;
										sc_val = {{56{item.data[7]}}, item.data};
									end
									C_FIXMAP, C_FIXARR: begin
										do_cont = 1'b1;
										c_map = (item.cls == C_FIXMAP);
										c_cnt = {28'd0, item.data[3:0]};
									end
									C_FIXSTR: begin
										do_str = 1'b1;
										s_len = {27'd0, item.data[4:0] & FIXLEN_MASK};
									end
									C_NIL: begin
										do_scalar = 1'b1;
										sc_kind = K_NULL;
									end
									C_FALSE: begin
										do_scalar = 1'b1;
										sc_kind = K_FALSE;
									end
									C_TRUE: begin
										do_scalar = 1'b1;
										sc_kind = K_TRUE;
									end
									C_COLLECT, C_STRHDR: begin
										do_collect = 1'b1;
									end
									default: begin
										do_fail = 1'b1;
										fail_code = E_UNSUP;
									end
								endcase
							end
						end
						P_COLLECT: begin
							vshift_d = nv;
							cbytes_d = (cbytes_q == 4'd0) ? 4'd0 : cbytes_q - 4'd1;
							if (cbytes_q <= 4'd1) begin
								case (hdr_q) inside
									HDR_F32: begin
										do_scalar = 1'b1;
										sc_kind = K_F32;
										sc_val = {32'd0, nv[31:0]};
									end
									HDR_F64: begin
										do_scalar = 1'b1;
										sc_kind = K_F64;
										sc_val = nv;
									end
									HDR_U8, HDR_U16, HDR_U32, HDR_I64: begin
										do_scalar = 1'b1;
										sc_kind = K_INT;
										sc_val = nv;
									end
									HDR_I8: begin
										do_scalar = 1'b1;
										sc_kind = K_INT;
										sc_val = {{56{nv[7]}}, nv[7:0]};
									end
									HDR_I16: begin
										do_scalar = 1'b1;
										sc_kind = K_INT;
										sc_val = {{48{nv[15]}}, nv[15:0]};
									end
									HDR_I32: begin
										do_scalar = 1'b1;
										sc_kind = K_INT;
										sc_val = {{32{nv[31]}}, nv[31:0]};
									end
									HDR_STR8, HDR_STR16, HDR_STR32: begin
										do_str = 1'b1;
										s_key = key_exp;
										s_len = nv[31:0];
									end
									HDR_ARR16, HDR_ARR32: begin
										do_cont = 1'b1;
										c_cnt = nv[31:0];
									end
									HDR_MAP16, HDR_MAP32: begin
										do_cont = 1'b1;
										c_map = 1'b1;
										c_cnt = nv[31:0];
									end
									default: begin
										do_fail = 1'b1;
										fail_code = E_UNSUP;
									end
								endcase
							end
						end
						P_STRB: begin
							ev_gen = 1'b1;
							ev.kind = K_STRBYTE;
							ev.value = {56'd0, item.data};
							ev.depth = d5(dp_q);
							srem_d = srem_q - 32'd1;
							if (srem_q == 32'd1) begin
								state_d = S_FIN;
							end
						end
						P_KEYB: begin
							ev_gen = 1'b1;
							ev.kind = K_KEYBYTE;
							ev.value = {56'd0, item.data};
							ev.depth = d5(dp_q);
							srem_d = srem_q - 32'd1;
							if (srem_q == 32'd1) begin
								if (dp_q != '0) begin
									top_await_d = 1'b0;
								end
								phase_d = P_HEADER;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_ECLOSE: begin
				ev_gen = 1'b1;
				ev.kind = K_CLOSE;
				ev.depth = d5(dp_q);
				state_d = S_FIN;
			end
			S_FIN: begin
				if (dp_q == '0) begin
					ev_gen = 1'b1;
					ev.kind = K_DONE;
					phase_d = P_DONE;
					state_d = S_EOB;
				end else begin
					if (top_map_q) begin
						top_await_d = 1'b1;
					end
					top_cnt_d = cm1;
					if (cm1 != 32'd0) begin
						phase_d = P_HEADER;
						state_d = S_EOB;
					end else begin
						dp_d = dp_m1;
						ev_gen = 1'b1;
						ev.kind = K_CLOSE;
						ev.depth = d5(dp_m1);
						if (dp_m1 == '0) begin
							state_d = S_FIN;
						end else begin
							mem_re = 1'b1;
							mem_raddr = dp_m2[AW-1:0];
							state_d = S_POPRD;
						end
					end
				end
			end
			S_POPRD: begin
				{top_cnt_d, top_map_d, top_await_d} = mem_rdata;
				state_d = S_FIN;
			end
			S_EOB: begin
				if (eob_q && phase_q != P_DONE && phase_q != P_ERROR) begin
					do_fail = 1'b1;
					fail_code = E_TRUNC;
				end
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// header actions
		if (do_scalar) begin
			ev_gen = 1'b1;
			ev.kind = sc_kind;
			ev.value = sc_val;
			ev.depth = d5(eff_dp);
			state_d = S_FIN;
		end
		if (do_collect) begin
			hdr_d = item.data;
			cbytes_d = operand_bytes(item.data);
			vshift_d = '0;
			phase_d = P_COLLECT;
		end
		if (do_str) begin
			if (s_key && s_len >= {24'd0, klimit_q}) begin
				do_fail = 1'b1;
				fail_code = E_KEYLEN;
			end else begin
				ev_gen = 1'b1;
				ev.kind = s_key ? K_KEY : K_STR;
				ev.length = s_len;
				ev.depth = d5(eff_dp);
				if (s_len == 32'd0) begin
					if (s_key) begin
						top_await_d = 1'b0;
						phase_d = P_HEADER;
					end else begin
						state_d = S_FIN;
					end
				end else begin
					srem_d = s_len;
					phase_d = s_key ? P_KEYB : P_STRB;
				end
			end
		end
		if (do_cont) begin
			dpx = {5'd0, eff_dp} + (DW+5)'(1);
			dp_p1 = dpx[DW-1:0];
			if (eff_dp >= DW'(MAX_DEPTH)) begin
				do_fail = 1'b1;
				fail_code = E_DEPTH;
			end else begin
				ev_gen = 1'b1;
				ev.kind = c_map ? K_MAP : K_ARRAY;
				ev.length = c_cnt;
				ev.depth = d5(dp_p1);
				if (c_cnt == 32'd0) begin
					state_d = S_ECLOSE;
				end else begin
					if (eff_dp != '0) begin
						mem_we = 1'b1;
						mem_waddr = dp_m1[AW-1:0];
					end
					top_cnt_d = c_cnt;
					top_map_d = c_map;
					top_await_d = 1'b1;
					dp_d = dp_p1;
					phase_d = P_HEADER;
				end
			end
		end
		if (do_fail) begin
			ev_gen = 1'b1;
			ev = '0;
			ev.kind = K_ERROR;
			ev.err = fail_code;
			ev.depth = d5(dp_d);
			phase_d = P_ERROR;
		end

		if (!go) begin
			mem_we = 1'b0;
			mem_re = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			hdr_q <= hdr_d;
			cbytes_q <= cbytes_d;
			vshift_q <= vshift_d;
			srem_q <= srem_d;
			top_cnt_q <= top_cnt_d;
			top_map_q <= top_map_d;
			top_await_q <= top_await_d;
			eob_q <= eob_d;
			if (ev_gen) begin
				hold_q <= ev;
				if (hold_v_q) begin
					out_q <= hold_q;
				end
			end else if (state_q == S_FLUSH && hold_v_q) begin
				out_q <= {hold_q[$bits(tok_t)-1:1], 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= P_ROOT;
			dp_q <= '0;
			klimit_q <= KLIMIT_RESET;
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				klimit_q <= cfg.key_length_limit;
			end
			if (out_v_q && tokens.ready) begin
				out_v_q <= 1'b0;
			end
			if (go) begin
				state_q <= state_d;
				phase_q <= phase_d;
				dp_q <= dp_d;
				if (ev_gen) begin
					hold_v_q <= 1'b1;
					if (hold_v_q) begin
						out_v_q <= 1'b1;
					end
				end else if (state_q == S_FLUSH && hold_v_q) begin
					hold_v_q <= 1'b0;
					out_v_q <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp_q <= DW'(MAX_DEPTH))
		else $error("nesting depth above limit");

	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POPRD |=> state_q == S_FIN)
		else $error("stack read not followed by reload");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && go) |=> !hold_v_q)
		else $error("hold stage not drained at end of byte");

	a_error_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ev_gen && ev.kind == K_ERROR) |=> phase_q == P_ERROR)
		else $error("error beat without error phase");
`endif

endmodule

// File: design/msgpack_stream_tokenizer_core.sv
// ----------------------------------------------------------------------------
// msgpack_stream_tokenizer_core
// MessagePack byte stream to token beats, with a container nesting stack.
//
//   channel  dir  beat
//   bytes    in   data_byte, end_of_buffer, start_of_message
//   tokens   out  token_kind, token_value, token_length, nest_depth,
//                 error_code, last_event
//   cfg      in   key_length_limit
//
// a byte passes through the idle, eob and flush states of the back sequencer,
// plus fin when it completes a value, plus a state per close and poprd for
// each close that reloads a parent from the stack ram
// a full output register stalls the back until the token beat is taken
// a two-entry queue lets the front take bytes while the back is busy
// the hold stage delays each token by one beat so last_event is known
// no clearing pass after reset; the stack ram is only read below the top
// ----------------------------------------------------------------------------
module msgpack_stream_tokenizer_core #(
	parameter int MAX_DEPTH = mst_pkg::DEF_MAX_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	mst_byte_if.sink    bytes,
	mst_cfg_if.sink     cfg,
	mst_token_if.source tokens
);
	import mst_pkg::*;

	mst_item_t item;
	logic      item_valid;
	logic      item_ready;

	mst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready)
	);

	mst_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cfg        (cfg),
		.tokens     (tokens)
	);

endmodule
